### hdl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, constants and helpers for the rolling band breakout block.
// ----------------------------------------------------------------------------
package rbb_pkg;

	// parameter defaults
	localparam int WINDOW_MAX_DEF = 64;
	localparam int PRICE_BITS_DEF = 24;

	// fixed field widths
	localparam int CASH_W  = 48;
	localparam int HOLD_W  = 9;
	localparam int ACT_W   = 2;
	localparam int WLEN_W  = 7;
	localparam int LIMIT_W = 8;
	localparam int MULT_W  = 4;

	// configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-3:0] REG_WLEN  = 2'd0;
	localparam logic [APB_AW-3:0] REG_LIMIT = 2'd1;
	localparam logic [APB_AW-3:0] REG_MULT  = 2'd2;

	localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd50;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd5;
	localparam logic [MULT_W-1:0]  MULT_RST  = 4'd2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BUY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SELL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DEC,
		ST_FIN
	} rbb_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic read;
		logic upd;
		logic mul1;
		logic mul2;
		logic mul3;
		logic dec;
		logic fin;
	} rbb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic last;
	} rbb_stat_t;

	// register block -> datapath
	typedef struct packed {
		logic [WLEN_W-1:0]  window_length;
		logic [LIMIT_W-1:0] position_limit;
		logic [MULT_W-1:0]  deviation_multiple;
		logic               restart;
	} rbb_cfg_t;

	// clamp a two-bit-wider signed value to the cash range
	function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W+1:0] v);
		logic signed [CASH_W-1:0] r;
		if ((v[CASH_W+1] == v[CASH_W]) && (v[CASH_W] == v[CASH_W-1]))
			r = v[CASH_W-1:0];
		else if (v[CASH_W+1])
			r = {1'b1, {(CASH_W-1){1'b0}}};
		else
			r = {1'b0, {(CASH_W-1){1'b1}}};
		return r;
	endfunction

endpackage

### hdl/rbb_in_if.sv
// ----------------------------------------------------------------------------
// rbb_in_if
// Price input channel: valid/ready with price and end-of-series flag.
// ----------------------------------------------------------------------------
interface rbb_in_if import rbb_pkg::*; #(
	parameter int PRICE_BITS = PRICE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] price;
	logic                  last_day;

	modport source (output valid, output price, output last_day, input ready);
	modport sink (input valid, input price, input last_day, output ready);
endinterface

### hdl/rbb_out_if.sv
// ----------------------------------------------------------------------------
// rbb_out_if
// Result channel: valid/ready with trade action, cash, holding and profit.
// ----------------------------------------------------------------------------
interface rbb_out_if import rbb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [CASH_W-1:0] cash_balance;
	logic signed [HOLD_W-1:0] holding;
	logic                     is_final;
	logic signed [CASH_W-1:0] final_profit;

	modport source (output valid, output action, output cash_balance, output holding,
		output is_final, output final_profit, input ready);
	modport sink (input valid, input action, input cash_balance, input holding,
		input is_final, input final_profit, output ready);
endinterface

### hdl/rbb_regs.sv
// ----------------------------------------------------------------------------
// rbb_regs
// APB configuration registers: window length, position limit, band multiple.
// ----------------------------------------------------------------------------
module rbb_regs import rbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output rbb_cfg_t          cfg
);
	logic [WLEN_W-1:0]  wlen_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [MULT_W-1:0]  mult_q;
	logic [APB_AW-3:0]  idx;
	logic               wr;

	assign idx = paddr[APB_AW-1:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WLEN_RST;
			limit_q <= LIMIT_RST;
			mult_q  <= MULT_RST;
		end else if (wr) begin
			case (idx)
				REG_WLEN:  wlen_q  <= pwdata[WLEN_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				REG_MULT:  mult_q  <= pwdata[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WLEN:  prdata = APB_DW'(wlen_q);
			REG_LIMIT: prdata = APB_DW'(limit_q);
			REG_MULT:  prdata = APB_DW'(mult_q);
			default:   prdata = '0;
		endcase
	end

	// a new window length starts a fresh series
	assign cfg.window_length      = wlen_q;
	assign cfg.position_limit     = limit_q;
	assign cfg.deviation_multiple = mult_q;
	assign cfg.restart            = wr && (idx == REG_WLEN);

endmodule

### hdl/rbb_ctrl.sv
// ----------------------------------------------------------------------------
// rbb_ctrl
// Sequencer: steps one price through window update, band test if full, result if full or last.
// ----------------------------------------------------------------------------
module rbb_ctrl import rbb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rbb_stat_t stat,
	output rbb_cmd_t  cmd
);
	rbb_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_UPD;
			ST_UPD: begin
				if (stat.full)
					state_d = ST_MUL1;
				else if (stat.last)
					state_d = ST_FIN;
				else
					state_d = ST_IDLE;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_DEC;
			ST_DEC:  state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ: cmd.read = 1'b1;
			ST_UPD:  cmd.upd  = 1'b1;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_MUL3: cmd.mul3 = 1'b1;
			ST_DEC:  cmd.dec  = 1'b1;
			ST_FIN:  cmd.fin  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/rbb_dpath.sv
// ----------------------------------------------------------------------------
// rbb_dpath
// Price ring, running sums, squared band test, position and cash tracking.
// ----------------------------------------------------------------------------
module rbb_dpath import rbb_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rbb_cmd_t                 cmd,
	input  rbb_cfg_t                 cfg,
	input  logic [PRICE_BITS-1:0]    price,
	input  logic                     last_day,
	output rbb_stat_t                stat,
	output logic [ACT_W-1:0]         action,
	output logic signed [CASH_W-1:0] cash_balance,
	output logic signed [HOLD_W-1:0] holding,
	output logic                     is_final,
	output logic signed [CASH_W-1:0] final_profit
);
	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int SUM_W  = PRICE_BITS + LEN_W;
	localparam int SQ_W   = 2 * PRICE_BITS + LEN_W;
	localparam int PSQ_W  = 2 * PRICE_BITS;
	localparam int D2_W   = 2 * SUM_W;
	localparam int V_W    = 2 * SUM_W;
	localparam int K2_W   = 2 * MULT_W;
	localparam int KV_W   = K2_W + V_W;
	localparam int WIDE_W = CASH_W + 2;
	localparam int PROD_W = PRICE_BITS + HOLD_W + 1;

	logic [PRICE_BITS-1:0] mem [WINDOW_MAX];

	// series state
	logic [SUM_W-1:0]         sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [LEN_W-1:0]         fill_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [HOLD_W-1:0] pos_q;
	logic signed [CASH_W-1:0] cash_q;

	// per-item working registers
	logic [PRICE_BITS-1:0] price_q;
	logic                  last_q;
	logic [ACT_W-1:0]      action_q;
	logic [SLOT_W-1:0]     slot_s1;
	logic [PRICE_BITS-1:0] old_s1;
	logic [PSQ_W-1:0]      psq_s1;
	logic [SUM_W-1:0]      ad_s2;
	logic                  dneg_s2;
	logic                  dpos_s2;
	logic [V_W-1:0]        lq_s2;
	logic [V_W-1:0]        ss_s2;
	logic [K2_W-1:0]       k2_s2;
	logic [D2_W-1:0]       d2_s3;
	logic [V_W-1:0]        v_s3;
	logic [KV_W-1:0]       kv_s4;

	logic [LEN_W-1:0]         len;
	logic [SLOT_W-1:0]        slot_rd;
	logic                     was_full;
	logic [PSQ_W-1:0]         old_sq;
	logic [SUM_W-1:0]         sum_nxt;
	logic [SQ_W-1:0]          sq_nxt;
	logic [SLOT_W-1:0]        slot_nxt;
	logic [SUM_W-1:0]         lp;
	logic                     band;
	logic signed [HOLD_W:0]   lim;
	logic signed [HOLD_W:0]   pos_x;
	logic                     buy;
	logic                     sell;
	logic signed [WIDE_W-1:0] price_w;
	logic signed [WIDE_W-1:0] cash_w;
	logic signed [PROD_W-1:0] value_p;
	logic signed [WIDE_W-1:0] profit_w;
	logic                     clr;

	// zero acts as one, oversize clamps to the ring depth
	always_comb begin
		if (cfg.window_length == '0)
			len = LEN_W'(1);
		else if (int'(cfg.window_length) > WINDOW_MAX)
			len = LEN_W'(WINDOW_MAX);
		else
			len = LEN_W'(cfg.window_length);
	end

	assign slot_rd  = (LEN_W'(slot_q) >= len) ? '0 : slot_q;
	assign was_full = (fill_q == len);
	assign old_sq   = PSQ_W'(old_s1) * PSQ_W'(old_s1);
	assign sum_nxt  = sum_q + SUM_W'(price_q) - (was_full ? SUM_W'(old_s1) : '0);
	assign sq_nxt   = sq_q + SQ_W'(psq_s1) - (was_full ? SQ_W'(old_sq) : '0);
	assign slot_nxt = (LEN_W'(slot_s1) + LEN_W'(1) >= len) ? '0 : slot_s1 + SLOT_W'(1);

	assign stat.full = was_full || (fill_q + LEN_W'(1) == len);
	assign stat.last = last_q;

	assign lp = SUM_W'(len) * SUM_W'(price_q);

	// d*d >= k*k*V stands for |price - mean| >= k deviations
	assign band  = KV_W'(d2_s3) >= kv_s4;
	assign lim   = $signed({2'b00, cfg.position_limit});
	assign pos_x = (HOLD_W+1)'(pos_q);
	assign buy   = band && !dneg_s2 && (pos_x < lim);
	assign sell  = !buy && band && !dpos_s2 && (pos_x > -lim);

	assign price_w  = WIDE_W'($signed({1'b0, price_q}));
	assign cash_w   = buy ? WIDE_W'(cash_q) - price_w : WIDE_W'(cash_q) + price_w;
	assign value_p  = PROD_W'($signed({1'b0, price_q})) * PROD_W'(pos_q);
	assign profit_w = WIDE_W'(cash_q) + WIDE_W'(value_p);

	assign clr = (cmd.fin && last_q) || cfg.restart;

	always_ff @(posedge clk) begin
		if (cmd.read)
			old_s1 <= mem[slot_rd];
		if (cmd.upd)
			mem[slot_s1] <= price_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			sq_q   <= '0;
			fill_q <= '0;
			slot_q <= '0;
			pos_q  <= '0;
			cash_q <= '0;
		end else if (clr) begin
			sum_q  <= '0;
			sq_q   <= '0;
			fill_q <= '0;
			slot_q <= '0;
			pos_q  <= '0;
			cash_q <= '0;
		end else if (cmd.upd) begin
			sum_q  <= sum_nxt;
			sq_q   <= sq_nxt;
			slot_q <= slot_nxt;
			if (!was_full)
				fill_q <= fill_q + LEN_W'(1);
		end else if (cmd.dec && (buy || sell)) begin
			cash_q <= sat_cash(cash_w);
			pos_q  <= buy ? pos_q + HOLD_W'(1) : pos_q - HOLD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q  <= price;
			last_q   <= last_day;
			action_q <= ACT_NONE;
		end
		if (cmd.read) begin
			slot_s1 <= slot_rd;
			psq_s1  <= PSQ_W'(price_q) * PSQ_W'(price_q);
		end
		if (cmd.mul1) begin
			dneg_s2 <= lp < sum_q;
			dpos_s2 <= lp > sum_q;
			ad_s2   <= (lp < sum_q) ? sum_q - lp : lp - sum_q;
			lq_s2   <= V_W'(len) * V_W'(sq_q);
			ss_s2   <= V_W'(sum_q) * V_W'(sum_q);
			k2_s2   <= K2_W'(cfg.deviation_multiple) * K2_W'(cfg.deviation_multiple);
		end
		if (cmd.mul2) begin
			d2_s3 <= D2_W'(ad_s2) * D2_W'(ad_s2);
			v_s3  <= lq_s2 - ss_s2;
		end
		if (cmd.mul3)
			kv_s4 <= KV_W'(k2_s2) * KV_W'(v_s3);
		if (cmd.dec)
			action_q <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
		if (cmd.fin) begin
			action       <= action_q;
			cash_balance <= cash_q;
			holding      <= pos_q;
			is_final     <= last_q;
			final_profit <= last_q ? sat_cash(profit_w) : '0;
		end
	end

endmodule

### hdl/rolling_band_breakout_signal.sv
// ----------------------------------------------------------------------------
// rolling_band_breakout_signal - rolling band breakout trade signal
// Full window: each accepted price goes through read, update, the registered
// band-test multiplies, decision and result; only then is the next price taken.
// Filling window: read and update only, plus the result step for a last price.
// Reset clears the series and restores the registers; the price ring is not
// cleared, the fill count keeps unwritten slots from being read.
// ----------------------------------------------------------------------------
module rolling_band_breakout_signal import rbb_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rbb_in_if.sink            item,
	rbb_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	rbb_cfg_t  cfg;
	rbb_cmd_t  cmd;
	rbb_stat_t stat;

	assign pready = 1'b1;

	rbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbb_dpath #(
		.WINDOW_MAX (WINDOW_MAX),
		.PRICE_BITS (PRICE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.price        (item.price),
		.last_day     (item.last_day),
		.stat         (stat),
		.action       (result.action),
		.cash_balance (result.cash_balance),
		.holding      (result.holding),
		.is_final     (result.is_final),
		.final_profit (result.final_profit)
	);

	// one price in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("price accepted while previous one still in progress");

	a_profit_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_final |-> result.final_profit == '0)
		else $error("profit reported on a non-final result");

	// a buy can never land on holding -255, nor a sell on +255, the ends the limit allows
	a_buy_holding: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.action == ACT_BUY) |-> result.holding != 9'h101)
		else $error("buy left holding at the short extreme");

	a_sell_holding: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.action == ACT_SELL) |-> result.holding != 9'h0FF)
		else $error("sell left holding at the long extreme");

endmodule

### tb/trade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_checker
// Watches the price, result and register transactions of the band breakout
// block. Keeps its own rolling window, sums and trading position, works out
// the trade that each price should cause, and compares every result
// transaction field by field with the oldest trade still owed.
// ----------------------------------------------------------------------------
module trade_checker import rbb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rbb_in_if                 item,
	rbb_out_if                result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	output int                failures,
	output int                outstanding
);
	localparam longint CASH_MAX = (64'sd1 <<< (CASH_W - 1)) - 1;
	localparam longint CASH_MIN = -CASH_MAX - 1;

	typedef struct {
		logic [ACT_W-1:0]         action;
		logic signed [CASH_W-1:0] cash_balance;
		logic signed [HOLD_W-1:0] holding;
		logic                     is_final;
		logic signed [CASH_W-1:0] final_profit;
	} trade_t;

	trade_t pending_trades[$];

	logic [PRICE_BITS_DEF-1:0] price_ring [WINDOW_MAX_DEF];
	longint sum_p, sum_sq, cash;
	int     fill, slot, position;
	int     fail_cnt = 0;

	logic [WLEN_W-1:0]  wlen;
	logic [LIMIT_W-1:0] limit;
	logic [MULT_W-1:0]  mult;

	function automatic longint clamp_cash(input longint v);
		if (v > CASH_MAX)
			return CASH_MAX;
		if (v < CASH_MIN)
			return CASH_MIN;
		return v;
	endfunction

	function automatic void start_series();
		sum_p    = 0;
		sum_sq   = 0;
		fill     = 0;
		slot     = 0;
		position = 0;
		cash     = 0;
	endfunction

	// one price in: roll the window, run the band test once full, trade, queue any result owed
	function automatic void advance_band(input logic [PRICE_BITS_DEF-1:0] price, input logic last);
		longint p, len, old, d, spread, k2, lim, profit;
		logic   band;
		trade_t t;
		p   = longint'(price);
		len = (wlen == 0) ? 1 : ((wlen > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : longint'(wlen));
		if (slot >= len)
			slot = 0;
		if (fill < len)
			fill++;
		else begin
			old = longint'(price_ring[slot]);
			sum_p -= old;
			sum_sq -= old * old;
		end
		price_ring[slot] = price;
		sum_p += p;
		sum_sq += p * p;
		slot = (slot + 1 >= len) ? 0 : slot + 1;

		t.action = ACT_NONE;
		if (fill == len) begin
			// squared distance against k^2 times the scaled variance, no root
			d      = len * p - sum_p;
			spread = len * sum_sq - sum_p * sum_p;
			k2     = longint'(mult) * longint'(mult);
			band   = (k2 == 0) || ((d * d) / k2 >= spread);
			lim    = longint'(limit);
			if (band && d >= 0 && position < lim) begin
				t.action = ACT_BUY;
				cash = clamp_cash(cash - p);
				position++;
			end else if (band && d <= 0 && position > -lim) begin
				t.action = ACT_SELL;
				cash = clamp_cash(cash + p);
				position--;
			end
		end else if (!last)
			return;

		t.cash_balance = cash[CASH_W-1:0];
		t.holding      = position[HOLD_W-1:0];
		t.is_final     = last;
		t.final_profit = '0;
		if (last) begin
			profit = clamp_cash(cash + p * position);
			t.final_profit = profit[CASH_W-1:0];
			start_series();
		end
		pending_trades = {pending_trades, t};
	endfunction

	function automatic void match_field(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_cnt++;
		end
	endfunction

	function automatic void compare_trade();
		trade_t t;
		if (pending_trades.size() == 0) begin
			$display("%0t: result transaction with no trade owed, expected none, actual action %0d",
				$time, result.action);
			fail_cnt++;
			return;
		end
		t = pending_trades.pop_front();
		match_field("action", t.action, result.action);
		match_field("cash_balance", t.cash_balance, result.cash_balance);
		match_field("holding", t.holding, result.holding);
		match_field("is_final", t.is_final, result.is_final);
		match_field("final_profit", t.final_profit, result.final_profit);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_trades.delete();
			start_series();
			wlen  = WLEN_RST;
			limit = LIMIT_RST;
			mult  = MULT_RST;
			failures    <= fail_cnt;
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready)
				compare_trade();
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_WLEN: begin
						wlen = pwdata[WLEN_W-1:0];
						start_series();
					end
					REG_LIMIT: limit = pwdata[LIMIT_W-1:0];
					REG_MULT:  mult  = pwdata[MULT_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				advance_band(item.price, item.last_day);
			failures    <= fail_cnt;
			outstanding <= pending_trades.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives price series and register writes into the band breakout block:
// a short directed set of corner series, then random walks with breakouts,
// noise and mid-series reconfiguration, long one-way trends, then more walks.
// Checking lives in trade_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import rbb_pkg::*;

	localparam int PRICE_MAX = (1 << PRICE_BITS_DEF) - 1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int failures;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;
	int items_sent;
	int eff_window;
	int series_left;
	int price_level;

	rbb_in_if  item_ch ();
	rbb_out_if result_ch ();

	rolling_band_breakout_signal dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	trade_checker u_trades (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.failures   (failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	task automatic send_price(input logic [PRICE_BITS_DEF-1:0] price, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.price    <= price;
		item_ch.last_day <= last;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// stop sending until every owed result is in and the pipe has drained
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == REG_WLEN)
			eff_window = (value[WLEN_W-1:0] == 0) ? 1 :
				((value[WLEN_W-1:0] > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : value[WLEN_W-1:0]);
	endtask

	task automatic reconfigure();
		logic [APB_DW-1:0] v;
		if ($urandom_range(0, 99) < 70) begin
			case ($urandom_range(0, 9))
				0:       v = 0;
				1:       v = 127;
				2:       v = WINDOW_MAX_DEF;
				3:       v = $urandom_range(9, 63);
				default: v = $urandom_range(1, 8);
			endcase
			write_reg(REG_WLEN, v);
		end
		if ($urandom_range(0, 99) < 60) begin
			case ($urandom_range(0, 9))
				0:       v = 0;
				1:       v = 255;
				2, 3, 4: v = $urandom_range(1, 6);
				default: v = $urandom_range(0, 255);
			endcase
			write_reg(REG_LIMIT, v);
		end
		if ($urandom_range(0, 99) < 60) begin
			case ($urandom_range(0, 9))
				0:          v = 0;
				1:          v = 15;
				2, 3, 4, 5: v = $urandom_range(1, 3);
				default:    v = $urandom_range(0, 15);
			endcase
			write_reg(REG_MULT, v);
		end
	endtask

	// random walk with occasional jumps to break out of the band, plus noise
	function automatic logic [PRICE_BITS_DEF-1:0] next_price();
		int r;
		int step;
		r = $urandom_range(0, 99);
		if (r < 5)
			return PRICE_BITS_DEF'($urandom);
		if (r < 8)
			return (r == 5) ? '0 : '1;
		step = int'($urandom_range(0, 400)) - 200;
		if (r < 22)
			step = step * 100;
		price_level = price_level + step;
		if (price_level < 0)
			price_level = 0;
		if (price_level > PRICE_MAX)
			price_level = PRICE_MAX;
		return price_level[PRICE_BITS_DEF-1:0];
	endfunction

	task automatic random_trading(input int target);
		logic last;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 2) begin
				settle();
				reconfigure();
			end else if ($urandom_range(0, 299) == 0)
				settle();
			last = (series_left == 0);
			send_price(next_price(), last);
			if (last) begin
				series_left = $urandom_range(0, 3 * eff_window + 6);
				price_level = $urandom_range(0, PRICE_MAX);
			end else
				series_left--;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		item_ch.valid    = 1'b0;
		item_ch.price    = '0;
		item_ch.last_day = 1'b0;
		result_ch.ready  = 1'b0;
		tx_idle_pct      = 26;
		rx_idle_pct      = 77;
		items_sent       = 0;
		eff_window       = WLEN_RST;
		series_left      = 0;
		price_level      = 1000000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// series closed before the window fills: one empty closing result
		send_price(24'd123456, 1'b1);
		settle();

		// two-price window at the extremes of the price range
		write_reg(REG_WLEN, 2);
		write_reg(REG_LIMIT, 2);
		write_reg(REG_MULT, 1);
		send_price('0, 1'b0);
		send_price(PRICE_BITS_DEF'(PRICE_MAX), 1'b0);
		send_price('0, 1'b0);
		send_price(PRICE_BITS_DEF'(PRICE_MAX), 1'b0);
		send_price(PRICE_BITS_DEF'(PRICE_MAX), 1'b1);
		settle();

		// single-price window: zero spread, every price sits on the band
		write_reg(REG_WLEN, 1);
		write_reg(REG_LIMIT, 3);
		write_reg(REG_MULT, 0);
		for (int i = 1; i <= 5; i++)
			send_price(PRICE_BITS_DEF'(i * 100), i == 5);
		settle();

		// limit lowered below the holding mid-series
		write_reg(REG_WLEN, 2);
		write_reg(REG_LIMIT, 255);
		write_reg(REG_MULT, 0);
		for (int i = 0; i < 8; i++)
			send_price(PRICE_BITS_DEF'(5000 + i * 700), 1'b0);
		settle();
		write_reg(REG_LIMIT, 2);
		send_price(PRICE_BITS_DEF'(11000), 1'b0);
		send_price(PRICE_BITS_DEF'(12000), 1'b0);
		send_price(PRICE_BITS_DEF'(9000), 1'b0);
		send_price(PRICE_BITS_DEF'(8000), 1'b1);
		settle();

		write_reg(REG_WLEN, 5);
		write_reg(REG_LIMIT, 4);
		write_reg(REG_MULT, 2);
		series_left = $urandom_range(0, 21);

		tx_idle_pct = 26;
		rx_idle_pct = 77;
		random_trading(items_sent + 500);
		tx_idle_pct = 77;
		rx_idle_pct = 26;
		random_trading(items_sent + 500);
		tx_idle_pct = 0;
		rx_idle_pct = 0;

		// long one-way trends push the holding to both ends of its allowed range
		settle();
		write_reg(REG_WLEN, 2);
		write_reg(REG_LIMIT, 255);
		write_reg(REG_MULT, 0);
		price_level = $urandom_range(0, 1000);
		for (int i = 0; i < 262; i++) begin
			price_level += $urandom_range(1, 4000);
			send_price(price_level[PRICE_BITS_DEF-1:0], i == 261);
		end
		price_level = PRICE_MAX - $urandom_range(0, 1000);
		for (int i = 0; i < 262; i++) begin
			price_level -= $urandom_range(1, 4000);
			send_price(price_level[PRICE_BITS_DEF-1:0], i == 261);
		end
		settle();
		reconfigure();
		series_left = $urandom_range(0, 3 * eff_window + 6);
		random_trading(items_sent + 100);

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
